// ===== rtl/mbdt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-button debounce package
// Shared constants, phase codes and the per-lane result type.
// ----------------------------------------------------------------------------
package mbdt_pkg;

   // Number of debouncer lanes and the width of the scan fields.
   localparam int BUTTONS    = 16;
   localparam int FIELD_BITS = 16;
   localparam int TIME_BITS  = 32;
   localparam int DT_BITS    = 16;

   // Reset value of the debounce time in milliseconds.
   localparam logic [DT_BITS-1:0] DEBOUNCE_RESET = DT_BITS'(50);

   // Debouncer phase codes.
   localparam logic [1:0] PH_IDLE      = 2'd0;
   localparam logic [1:0] PH_PRESSING  = 2'd1;
   localparam logic [1:0] PH_PRESSED   = 2'd2;
   localparam logic [1:0] PH_RELEASING = 2'd3;

   // What one lane reports for the scan it just processed.
   typedef struct packed {
      logic press;
      logic release_evt;
      logic level;
      logic led;
   } lane_out_type;

endpackage
`default_nettype wire

// ===== rtl/multi_button_debounce_toggle_unit.sv =====
`default_nettype none
// Output: a scan's result is registered and valid in the cycle after its transfer.
// Throughput: one scan per cycle while results are taken; a result left waiting holds
// off new scans, and the output register is reloaded while its old result is being taken.
// Reset: synchronous, active high; all buttons idle, stamps zero, LEDs off,
// debounce time 50 ms, no result pending.
// ----------------------------------------------------------------------------
// Multi-button debounce and toggle unit
// Per-button debouncers run as parallel lanes; a merge stage registers the
// press, release, level and LED vectors for each scan.
// ----------------------------------------------------------------------------
module multi_button_debounce_toggle_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [mbdt_pkg::FIELD_BITS-1:0]      req_raw_buttons,
   input  wire logic [mbdt_pkg::TIME_BITS-1:0]       req_now_ms,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [mbdt_pkg::FIELD_BITS-1:0]           rsp_press_events,
   output logic [mbdt_pkg::FIELD_BITS-1:0]           rsp_release_events,
   output logic [mbdt_pkg::FIELD_BITS-1:0]           rsp_debounced_levels,
   output logic [mbdt_pkg::FIELD_BITS-1:0]           rsp_led_states,
   input  wire logic                                 csr_write_enable,
   input  wire logic [mbdt_pkg::DT_BITS-1:0]         csr_write_data
);

   logic [mbdt_pkg::DT_BITS-1:0]                     debounce_time_ff;
   logic                                             accept;
   mbdt_pkg::lane_out_type [mbdt_pkg::BUTTONS-1:0]   lanes;

   // Debounce time register.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff <= mbdt_pkg::DEBOUNCE_RESET;
      end else if (csr_write_enable) begin
         debounce_time_ff <= csr_write_data;
      end
   end

   // A scan is taken whenever the output register is free or being emptied.
   assign req_ready = !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;

   // One debouncer per button; lanes beyond the field width read as released.
   for (genvar i = 0; i < mbdt_pkg::BUTTONS; i++) begin : g_lane
      logic pressed_raw;
      if (i < mbdt_pkg::FIELD_BITS) begin : g_raw
         assign pressed_raw = !req_raw_buttons[i];
      end else begin : g_none
         assign pressed_raw = 1'b0;
      end

      mbdt_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .advance       (accept),
         .pressed_raw   (pressed_raw),
         .now_ms        (req_now_ms),
         .debounce_time (debounce_time_ff),
         .result        (lanes[i])
      );
   end

   // Merge the lane reports into the registered result.
   mbdt_merge u_merge (
      .clock                (clock),
      .reset                (reset),
      .load                 (accept),
      .lanes                (lanes),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_press_events     (rsp_press_events),
      .rsp_release_events   (rsp_release_events),
      .rsp_debounced_levels (rsp_debounced_levels),
      .rsp_led_states       (rsp_led_states)
   );

endmodule
`default_nettype wire

// ===== rtl/mbdt_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Debounce lane
// One button's four-phase debouncer with its change stamp and toggle bit.
// ----------------------------------------------------------------------------
module mbdt_lane (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic                                pressed_raw,
   input  wire logic [mbdt_pkg::TIME_BITS-1:0]      now_ms,
   input  wire logic [mbdt_pkg::DT_BITS-1:0]        debounce_time,
   output mbdt_pkg::lane_out_type                   result
);

   logic [1:0]                           phase_ff, phase_in;
   logic [mbdt_pkg::TIME_BITS-1:0]       stamp_ff, stamp_in;
   logic                                 toggle_ff, toggle_in;
   logic [mbdt_pkg::TIME_BITS-1:0]       elapsed;
   logic                                 held;
   logic                                 press, release_evt;

   // Elapsed time wraps modulo 2^32.
   assign elapsed = now_ms - stamp_ff;
   assign held    = elapsed >= {{(mbdt_pkg::TIME_BITS-mbdt_pkg::DT_BITS){1'b0}}, debounce_time};

   // Next phase for this scan.
   always_comb begin
      phase_in    = phase_ff;
      stamp_in    = stamp_ff;
      press       = 1'b0;
      release_evt = 1'b0;
      case (phase_ff)
         mbdt_pkg::PH_IDLE: begin
            if (pressed_raw) begin
               phase_in = mbdt_pkg::PH_PRESSING;
               stamp_in = now_ms;
            end
         end
         mbdt_pkg::PH_PRESSING: begin
            if (!pressed_raw) begin
               phase_in = mbdt_pkg::PH_IDLE;
            end else if (held) begin
               phase_in = mbdt_pkg::PH_PRESSED;
               press    = 1'b1;
            end
         end
         mbdt_pkg::PH_PRESSED: begin
            if (!pressed_raw) begin
               phase_in = mbdt_pkg::PH_RELEASING;
               stamp_in = now_ms;
            end
         end
         default: begin
            if (pressed_raw) begin
               phase_in = mbdt_pkg::PH_PRESSED;
            end else if (held) begin
               phase_in    = mbdt_pkg::PH_IDLE;
               release_evt = 1'b1;
            end
         end
      endcase
      toggle_in = toggle_ff ^ press;
   end

   // State advances only when a scan is transferred.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mbdt_pkg::PH_IDLE;
         stamp_ff  <= '0;
         toggle_ff <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         stamp_ff  <= stamp_in;
         toggle_ff <= toggle_in;
      end
   end

   // Report the values after this scan.
   assign result.press       = press;
   assign result.release_evt = release_evt;
   assign result.level       = (phase_in == mbdt_pkg::PH_PRESSED) ||
                               (phase_in == mbdt_pkg::PH_RELEASING);
   assign result.led         = toggle_in;

endmodule
`default_nettype wire

// ===== rtl/mbdt_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Lane merge and output register
// Gathers the lane reports into result vectors and holds them for transfer.
// ----------------------------------------------------------------------------
module mbdt_merge (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              load,
   input  mbdt_pkg::lane_out_type [mbdt_pkg::BUTTONS-1:0]         lanes,
   input  wire logic                                              rsp_ready,
   output logic                                                   rsp_valid,
   output logic [mbdt_pkg::FIELD_BITS-1:0]                        rsp_press_events,
   output logic [mbdt_pkg::FIELD_BITS-1:0]                        rsp_release_events,
   output logic [mbdt_pkg::FIELD_BITS-1:0]                        rsp_debounced_levels,
   output logic [mbdt_pkg::FIELD_BITS-1:0]                        rsp_led_states
);

   logic [mbdt_pkg::FIELD_BITS-1:0] press_in, release_in, level_in, led_in;
   logic [mbdt_pkg::FIELD_BITS-1:0] press_ff, release_ff, level_ff, led_ff;
   logic                            valid_ff, valid_in;

   // Only lanes inside the field width appear in the outputs.
   for (genvar i = 0; i < mbdt_pkg::FIELD_BITS; i++) begin : g_bit
      if (i < mbdt_pkg::BUTTONS) begin : g_lane
         assign press_in[i]   = lanes[i].press;
         assign release_in[i] = lanes[i].release_evt;
         assign level_in[i]   = lanes[i].level;
         assign led_in[i]     = lanes[i].led;
      end else begin : g_none
         assign press_in[i]   = 1'b0;
         assign release_in[i] = 1'b0;
         assign level_in[i]   = 1'b0;
         assign led_in[i]     = 1'b0;
      end
   end

   // The result stays valid until its transfer; a new load replaces it.
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         press_ff   <= press_in;
         release_ff <= release_in;
         level_ff   <= level_in;
         led_ff     <= led_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_press_events     = press_ff;
   assign rsp_release_events   = release_ff;
   assign rsp_debounced_levels = level_ff;
   assign rsp_led_states       = led_ff;

endmodule
`default_nettype wire
